// ----- sv/table_driven_dfa_matcher_macros.svh -----
// assertion helpers used by the checker file tdfa_checker.sv
`ifndef TABLE_DRIVEN_DFA_MATCHER_MACROS_SVH
`define TABLE_DRIVEN_DFA_MATCHER_MACROS_SVH

// checked only outside reset
`define TDFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define TDFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/tdfa_pkg.sv -----
package tdfa_pkg;

    localparam int MAX_RULES   = 256;
    localparam int MAX_STATES  = 64;
    localparam int RULE_IDX_W  = $clog2(MAX_RULES);
    localparam int ACC_IDX_W   = $clog2(MAX_STATES);
    localparam int CNT_W       = $clog2(MAX_RULES + 1);
    localparam int STATE_W     = 6;
    localparam int SYM_W       = 8;
    localparam int RULE_W      = 2 * STATE_W + SYM_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    typedef enum logic [1:0] {
        OP_WRITE_RULE   = 2'd0,
        OP_WRITE_ACCEPT = 2'd1,
        OP_RESTART      = 2'd2,
        OP_CONSUME      = 2'd3
    } opcode_t;

    typedef enum logic {
        REG_RULES_IN_USE = 1'b0,
        REG_START_STATE  = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_LOOKUP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
    } rule_t;

    typedef struct packed {
        logic               start;
        logic [CNT_W-1:0]   limit;
        logic [STATE_W-1:0] cur_state;
        logic [SYM_W-1:0]   symbol;
    } search_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [STATE_W-1:0] to_state;
    } search_rsp_t;

endpackage

// ----- sv/tdfa_ram.sv -----
module tdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tdfa_search.sv -----
module tdfa_search
    import tdfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  search_req_t           req,
    input  logic [RULE_W-1:0]     rd_data,
    output logic [RULE_IDX_W-1:0] rd_addr,
    output search_rsp_t           rsp
);

    logic               busy_reg, busy_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic [STATE_W-1:0] state_reg, state_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;

    rule_t rule;
    logic  issue;
    logic  hit;
    logic  done;

    assign rule    = rule_t'(rd_data);
    // read of entry rd_idx goes out now, its compare happens next cycle
    assign issue   = busy_reg && (rd_idx_reg < limit_reg);
    assign hit     = pend_reg && (rule.from_state == state_reg) && (rule.symbol == sym_reg);
    assign done    = busy_reg && (hit || (!pend_reg && !issue));
    assign rd_addr = rd_idx_reg[RULE_IDX_W-1:0];

    assign rsp.done     = done;
    assign rsp.hit      = hit;
    assign rsp.to_state = rule.to_state;

    always_comb begin
        busy_next   = busy_reg;
        pend_next   = pend_reg;
        rd_idx_next = rd_idx_reg;
        limit_next  = limit_reg;
        state_next  = state_reg;
        sym_next    = sym_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            pend_next   = 1'b0;
            rd_idx_next = '0;
            limit_next  = req.limit;
            state_next  = req.cur_state;
            sym_next    = req.symbol;
        end else if (busy_reg) begin
            if (done) begin
                busy_next = 1'b0;
                pend_next = 1'b0;
            end else begin
                pend_next   = issue;
                rd_idx_next = rd_idx_reg + CNT_W'(issue);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            rd_idx_reg <= rd_idx_next;
        end
        limit_reg <= limit_next;
        state_reg <= state_next;
        sym_reg   <= sym_next;
    end

endmodule

// ----- sv/table_driven_dfa_matcher.sv -----
// Table-driven DFA matcher. Each input word carries an opcode in s_tuser: write a rule entry,
// write an accept bit, restart at start_state, or consume one symbol; every word gives
// exactly one result word with the state, the trap flag and the accept flag. After reset a
// clearing pass zeroes all 64 entries of the accept map memory, with s_tready low. Rule
// writes, accept writes, restarts and symbols that arrive while trapped go through ST_LOOKUP
// and ST_DONE before m_tvalid rises. A symbol otherwise searches the rule memory, which has
// one read port: the rules are compared in index order, one per cycle, over at most
// min(rules_in_use, 256) entries, stopping at the first hit. In ST_LOOKUP the accept bit
// of the new state is read from its memory. s_tready is low while an item is in work; a
// finished result sits in the output register, so the next word can be taken while it waits.
// Only entries below rules_in_use are searched, so they must have been written first.
module table_driven_dfa_matcher
    import tdfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // rule_index, rule_from, in_symbol, rule_to,
                                            // accept_value, zero pad
    input  logic [1:0]            s_tuser,  // opcode
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata   // current_state, trapped, accepted
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      rules_in_use_reg;
    logic [STATE_W-1:0]    start_state_reg;
    logic [STATE_W-1:0]    cur_state_reg, cur_state_next;
    logic                  trap_reg, trap_next;
    logic [ACC_IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg, m_tdata_next;

    opcode_t            in_opcode;
    logic [7:0]         in_rule_index;
    logic [STATE_W-1:0] in_rule_from;
    logic [SYM_W-1:0]   in_symbol;
    logic [STATE_W-1:0] in_rule_to;
    logic               in_accept_value;

    logic        in_fire;
    logic        cfg_wr;
    logic        rule_wr;
    logic [CNT_W-1:0] limit;
    logic        cur_accepting;

    logic                 acc_clear;
    logic                 acc_wr_en;
    logic [ACC_IDX_W-1:0] acc_wr_addr;
    logic                 acc_wr_data;
    logic                 acc_rd_data;

    search_req_t           search_req;
    search_rsp_t           search_rsp;
    logic [RULE_IDX_W-1:0] rd_addr;
    logic [RULE_W-1:0]     rd_data;
    rule_t                 wr_rule;

    assign in_opcode       = opcode_t'(s_tuser);
    assign in_rule_index   = s_tdata[7:0];
    assign in_rule_from    = s_tdata[13:8];
    assign in_symbol       = s_tdata[21:14];
    assign in_rule_to      = s_tdata[27:22];
    assign in_accept_value = s_tdata[28];

    assign in_fire = s_tvalid && s_tready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // counts above the table size saturate
    assign limit = (rules_in_use_reg > CNT_W'(MAX_RULES)) ? CNT_W'(MAX_RULES)
                                                          : rules_in_use_reg;

    always_comb begin
        unique case (reg_sel_t'(paddr[2]))
            REG_RULES_IN_USE: prdata = CFG_DATA_W'(rules_in_use_reg);
            REG_START_STATE:  prdata = CFG_DATA_W'(start_state_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rules_in_use_reg <= '0;
            start_state_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel_t'(paddr[2]))
                REG_RULES_IN_USE: rules_in_use_reg <= pwdata[CNT_W-1:0];
                REG_START_STATE:  start_state_reg  <= pwdata[STATE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign rule_wr = in_fire && (in_opcode == OP_WRITE_RULE)
                     && (32'(in_rule_index) < MAX_RULES);
    assign wr_rule.from_state = in_rule_from;
    assign wr_rule.symbol     = in_symbol;
    assign wr_rule.to_state   = in_rule_to;

    tdfa_ram #(
        .WIDTH(RULE_W),
        .DEPTH(MAX_RULES)
    ) u_rule_ram (
        .aclk   (aclk),
        .wr_en  (rule_wr),
        .wr_addr(RULE_IDX_W'(in_rule_index)),
        .wr_data(wr_rule),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign search_req.start     = in_fire && (in_opcode == OP_CONSUME) && !trap_reg;
    assign search_req.limit     = limit;
    assign search_req.cur_state = cur_state_reg;
    assign search_req.symbol    = in_symbol;

    tdfa_search u_search (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (search_req),
        .rd_data(rd_data),
        .rd_addr(rd_addr),
        .rsp    (search_rsp)
    );

    // the clearing pass owns the write port until it ends
    assign acc_clear   = (state_reg == ST_CLEAR);
    assign acc_wr_en   = acc_clear || (in_fire && (in_opcode == OP_WRITE_ACCEPT)
                                       && (32'(in_rule_to) < MAX_STATES));
    assign acc_wr_addr = acc_clear ? clr_idx_reg : ACC_IDX_W'(in_rule_to);
    assign acc_wr_data = !acc_clear && in_accept_value;

    tdfa_ram #(
        .WIDTH(1),
        .DEPTH(MAX_STATES)
    ) u_accept_ram (
        .aclk   (aclk),
        .wr_en  (acc_wr_en),
        .wr_addr(acc_wr_addr),
        .wr_data(acc_wr_data),
        .rd_addr(ACC_IDX_W'(cur_state_reg)),
        .rd_data(acc_rd_data)
    );

    assign cur_accepting = (32'(cur_state_reg) < MAX_STATES) && acc_rd_data;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cur_state_next = cur_state_reg;
        trap_next      = trap_reg;
        clr_idx_next   = clr_idx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + ACC_IDX_W'(1);
                if (clr_idx_reg == ACC_IDX_W'(MAX_STATES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (search_req.start) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_LOOKUP;
                    end
                    if (in_opcode == OP_RESTART) begin
                        cur_state_next = start_state_reg;
                        trap_next      = 1'b0;
                    end
                end
            end
            ST_SEARCH: begin
                if (search_rsp.done) begin
                    if (search_rsp.hit) begin
                        cur_state_next = search_rsp.to_state;
                    end else begin
                        trap_next = 1'b1;
                    end
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // accept bit of the settled state is read here, any fresh write included
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {!trap_reg && cur_accepting, trap_reg, cur_state_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cur_state_reg <= '0;
            trap_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_state_reg <= cur_state_next;
            trap_reg      <= trap_next;
            clr_idx_reg   <= clr_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/tdfa_checker.sv -----
`include "table_driven_dfa_matcher_macros.svh"

module tdfa_checker
    import tdfa_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [31:0]           s_tdata,  // rule_index, rule_from, in_symbol, rule_to,
                                           // accept_value, zero pad
    input logic [1:0]            s_tuser,  // opcode
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata   // current_state, trapped, accepted
);

    // a trapped run never reports a match
    `TDFA_ASSERT(a_no_accept_when_trapped, m_tvalid |-> !(m_tdata[6] && m_tdata[7]),
        "accepted set while trapped")

    // one item in work at a time
    `TDFA_ASSERT(a_busy_after_take, (s_tvalid && s_tready) |=> !s_tready,
        "second word taken while one is in work")

    // a waiting result word holds
    `TDFA_ASSERT(a_result_held, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "result word changed while stalled")

    // reset drops any pending result and holds off input for the clearing pass
    `TDFA_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (!m_tvalid && !s_tready),
        "state after reset not clean")

endmodule

bind table_driven_dfa_matcher tdfa_checker u_tdfa_checker (.*);
